>>> sv/gbs_pkg.sv
// package for the 3x3 grid box smoother
// shared constants, config register codes and structs; no dependencies
package gbs_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COLSUM_W    = SAMPLE_W + 2;
  localparam int SUM_W       = SAMPLE_W + 4;
  localparam int X_W         = SAMPLE_W + 4;
  localparam int RECIP_SHIFT = X_W + 4;
  localparam int RECIP_W     = RECIP_SHIFT - 2;
  localparam int PROD_W      = X_W + RECIP_W;
  localparam int MEAN_SHIFT  = RECIP_SHIFT + 1;

  // ceil(2^RECIP_SHIFT / 9), exact floor(x / 9) for all x below 2^X_W
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd8) / 64'd9);

  localparam int ROWS_CFG_W = 13;
  localparam int COLS_CFG_W = 11;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 13'd256;
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = 11'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_reg_e;

  // one window column: two rows above, row above, current row, and its sum
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] top;
    logic signed [SAMPLE_W-1:0] mid;
    logic signed [SAMPLE_W-1:0] bot;
    logic signed [COLSUM_W-1:0] sum;
  } column_t;

  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } item_ctrl_t;

  typedef struct packed {
    logic load_c;
    logic load_d;
    logic load_e;
  } mean_load_t;

endpackage

>>> sv/gbs_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
module gbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/gbs_cell.sv
// one column cell of the 3x3 window chain
// depends on gbs_pkg
module gbs_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  gbs_pkg::column_t col_i,
  output gbs_pkg::column_t col_o
);

  gbs_pkg::column_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

>>> sv/gbs_mean9.sv
// three-stage divide of a nine-sample sum by 9, rounded half away from zero
// depends on gbs_pkg
module gbs_mean9 (
  input  logic                                 clk_i,
  input  gbs_pkg::mean_load_t                  load_i,
  input  logic signed [gbs_pkg::SUM_W-1:0]     sum_i,
  output logic signed [gbs_pkg::SAMPLE_W-1:0]  mean_o
);

  localparam int SW = gbs_pkg::SAMPLE_W;

  logic signed [gbs_pkg::SUM_W-1:0] sum_q;
  logic [gbs_pkg::SUM_W-1:0]        mag;
  logic [gbs_pkg::X_W-1:0]          x_d, x_q;
  logic                             neg_d_q, neg_e_q;
  logic [gbs_pkg::PROD_W-1:0]       prod_q;
  logic [SW-1:0]                    quot;

  // magnitude fits in SUM_W-1 bits, so twice it plus 9 fits in X_W
  assign mag = sum_q[gbs_pkg::SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
  assign x_d = {mag[gbs_pkg::SUM_W-2:0], 1'b0} + gbs_pkg::X_W'(9);

  always_ff @(posedge clk_i) begin
    if (load_i.load_c) begin
      sum_q <= sum_i;
    end
    if (load_i.load_d) begin
      x_q     <= x_d;
      neg_d_q <= sum_q[gbs_pkg::SUM_W-1];
    end
    if (load_i.load_e) begin
      prod_q  <= gbs_pkg::PROD_W'(x_q) * gbs_pkg::PROD_W'(gbs_pkg::RECIP);
      neg_e_q <= neg_d_q;
    end
  end

  // floor(x / 18) = floor(floor(x / 9) / 2)
  assign quot   = prod_q[gbs_pkg::MEAN_SHIFT +: SW];
  assign mean_o = neg_e_q ? $signed(~quot + 1'b1) : $signed(quot);

endmodule

>>> sv/grid_box_smoother_3x3.sv
// top level of the 3x3 grid box smoother; depends on gbs_pkg, gbs_ram, gbs_cell, gbs_mean9
// the transfer that releases a result passes stages a to e, then the output register holds it
// throughput: one input transfer per cycle, set by the RAM read port, unless output stalls
// reset: async, clears counters, valids and window cells; config back to 256 x 256
// line buffers are not cleared and hold undefined data until written
module grid_box_smoother_3x3 #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gbs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gbs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [gbs_pkg::SAMPLE_W-1:0]      s_axis_tdata_i,  // [15:0] sample
  input  logic                              s_axis_tuser_i,  // [0] drain
  // output stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [gbs_pkg::SAMPLE_W-1:0]      m_axis_tdata_o,  // [15:0] smoothed
  output logic                              m_axis_tlast_o   // last_of_grid
);

  localparam int SW     = gbs_pkg::SAMPLE_W;
  localparam int WORD_W = 2 * SW;
  localparam int AW     = $clog2(MAX_COLS);
  localparam int CW     = $clog2(MAX_COLS + 1);
  localparam int RW     = $clog2(MAX_ROWS + 1);
  localparam int CCW    = (CW > gbs_pkg::COLS_CFG_W) ? CW : gbs_pkg::COLS_CFG_W;
  localparam int RCW    = (RW > gbs_pkg::ROWS_CFG_W) ? RW : gbs_pkg::ROWS_CFG_W;

  function automatic logic [RW-1:0] inc_sat(input logic [RW-1:0] r);
    logic [RW-1:0] res;
    res = (r == RW'(MAX_ROWS)) ? r : r + RW'(1);
    return res;
  endfunction

  // config registers
  logic [gbs_pkg::ROWS_CFG_W-1:0] rows_cfg_q;
  logic [gbs_pkg::COLS_CFG_W-1:0] cols_cfg_q;
  logic [RCW-1:0]                 rows_wide;
  logic [CCW-1:0]                 cols_wide;
  logic [RW-1:0]                  rows_eff;
  logic [CW-1:0]                  cols_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= gbs_pkg::ROWS_RESET;
      cols_cfg_q <= gbs_pkg::COLS_RESET;
    end else if (cfg_valid_i) begin
      case (gbs_pkg::cfg_reg_e'(cfg_index_i))
        gbs_pkg::CFG_ROWS: begin
          rows_cfg_q <= cfg_data_i[gbs_pkg::ROWS_CFG_W-1:0];
        end
        gbs_pkg::CFG_COLS: begin
          cols_cfg_q <= cfg_data_i[gbs_pkg::COLS_CFG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign rows_wide = RCW'(rows_cfg_q);
  assign cols_wide = CCW'(cols_cfg_q);
  assign rows_eff  = (rows_wide == '0) ? RW'(1) :
                     (rows_wide > RCW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_wide);
  assign cols_eff  = (cols_wide == '0) ? CW'(1) :
                     (cols_wide > CCW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cols_wide);

  // pipeline flow control
  logic valid_a_q, valid_b_q, valid_c_q, valid_d_q, valid_e_q, out_valid_q;
  logic free_a, free_b, free_c, free_d, free_e, out_free;
  logic s_accept;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign free_e   = !valid_e_q || out_free;
  assign free_d   = !valid_d_q || free_e;
  assign free_c   = !valid_c_q || free_d;
  assign free_b   = !valid_b_q || free_c;
  assign free_a   = !valid_a_q || free_b;

  assign s_axis_tready_o = free_a;
  assign s_accept        = s_axis_tvalid_i && free_a;

  // position counters
  logic [AW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [AW-1:0] ic, oc;
  logic [RW-1:0] ir, orow;
  logic [CW-1:0] ic_inc, oc_inc;
  logic [RW:0]   orow_inc, rows_x;
  logic          in_wrap, out_wrap, ic_end, oc_end;
  gbs_pkg::item_ctrl_t ctrl_in;
  logic signed [SW-1:0] s_in;

  always_comb begin
    in_wrap  = CW'(in_col_q) >= cols_eff;
    ic       = in_wrap ? '0 : in_col_q;
    ir       = in_wrap ? inc_sat(in_row_q) : in_row_q;
    out_wrap = CW'(out_col_q) >= cols_eff;
    oc       = out_wrap ? '0 : out_col_q;
    orow     = out_wrap ? inc_sat(out_row_q) : out_row_q;

    ic_inc   = CW'(ic) + CW'(1);
    oc_inc   = CW'(oc) + CW'(1);
    ic_end   = ic_inc >= cols_eff;
    oc_end   = oc_inc >= cols_eff;
    orow_inc = (RW + 1)'(orow) + (RW + 1)'(1);
    rows_x   = (RW + 1)'(rows_eff);

    ctrl_in.emit     = !((ir == '0) || ((ir == RW'(1)) && (ic == '0)));
    ctrl_in.interior = (orow != '0) && (orow_inc < rows_x) &&
                       (oc != '0) && (oc_inc < cols_eff);
    ctrl_in.last     = (orow_inc >= rows_x) && (oc_inc >= cols_eff);

    s_in = (s_axis_tuser_i || (ir >= rows_eff)) ? '0 : $signed(s_axis_tdata_i);

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (s_accept) begin
      in_col_d = ic_end ? '0 : AW'(ic_inc);
      in_row_d = ic_end ? inc_sat(ir) : ir;
      if (ctrl_in.emit) begin
        out_col_d = oc_end ? '0 : AW'(oc_inc);
        out_row_d = oc_end ? inc_sat(orow) : orow;
        if (ctrl_in.last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end
      end else begin
        out_col_d = oc;
        out_row_d = orow;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // stage a: line buffer read data lines up with the accepted item
  logic signed [SW-1:0] s_a_q;
  gbs_pkg::item_ctrl_t  ctrl_a_q;
  logic [AW-1:0]        addr_a_q;
  logic                 fwd_d, fwd_q;
  logic [WORD_W-1:0]    fwd_word_q, word_a, ram_rdata, wdata_a;
  logic signed [SW-1:0] above_a, two_a;
  logic                 wr_a;
  gbs_pkg::column_t     chain [4];

  assign word_a  = fwd_q ? fwd_word_q : ram_rdata;
  assign above_a = $signed(word_a[SW-1:0]);
  assign two_a   = $signed(word_a[WORD_W-1:SW]);
  assign wr_a    = valid_a_q && free_b;
  assign wdata_a = {above_a, s_a_q};
  // a read of the entry written in the same cycle takes the written word
  assign fwd_d   = wr_a && (addr_a_q == ic);

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s_a_q      <= s_in;
      ctrl_a_q   <= ctrl_in;
      addr_a_q   <= ic;
      fwd_q      <= fwd_d;
      fwd_word_q <= wdata_a;
    end
  end

  // word: upper half two rows above, lower half row above
  gbs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_COLS)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (wr_a),
    .waddr_i (addr_a_q),
    .wdata_i (wdata_a),
    .re_i    (s_accept),
    .raddr_i (ic),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    chain[3].top = two_a;
    chain[3].mid = above_a;
    chain[3].bot = s_a_q;
    chain[3].sum = gbs_pkg::COLSUM_W'(two_a) + gbs_pkg::COLSUM_W'(above_a) +
                   gbs_pkg::COLSUM_W'(s_a_q);
  end

  // stage b: window of three column cells
  for (genvar k = 0; k < 3; k++) begin : g_cell
    gbs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (wr_a),
      .col_i   (chain[k+1]),
      .col_o   (chain[k])
    );
  end

  gbs_pkg::item_ctrl_t ctrl_b_q, ctrl_c_q, ctrl_d_q, ctrl_e_q;
  logic signed [SW-1:0] center_c_q, center_d_q, center_e_q, mean;
  logic signed [gbs_pkg::SUM_W-1:0] sum_b;
  gbs_pkg::mean_load_t mean_load;

  assign sum_b = gbs_pkg::SUM_W'($signed(chain[0].sum)) +
                 gbs_pkg::SUM_W'($signed(chain[1].sum)) +
                 gbs_pkg::SUM_W'($signed(chain[2].sum));

  assign mean_load.load_c = free_c;
  assign mean_load.load_d = free_d;
  assign mean_load.load_e = free_e;

  gbs_mean9 u_mean9 (
    .clk_i  (clk_i),
    .load_i (mean_load),
    .sum_i  (sum_b),
    .mean_o (mean)
  );

  always_ff @(posedge clk_i) begin
    if (free_b) begin
      ctrl_b_q <= ctrl_a_q;
    end
    if (free_c) begin
      ctrl_c_q   <= ctrl_b_q;
      center_c_q <= chain[1].mid;
    end
    if (free_d) begin
      ctrl_d_q   <= ctrl_c_q;
      center_d_q <= center_c_q;
    end
    if (free_e) begin
      ctrl_e_q   <= ctrl_d_q;
      center_e_q <= center_d_q;
    end
  end

  // output register
  logic [SW-1:0] out_data_q;
  logic          out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q   <= 1'b0;
      valid_b_q   <= 1'b0;
      valid_c_q   <= 1'b0;
      valid_d_q   <= 1'b0;
      valid_e_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (free_a) valid_a_q <= s_axis_tvalid_i;
      if (free_b) valid_b_q <= valid_a_q;
      if (free_c) valid_c_q <= valid_b_q;
      if (free_d) valid_d_q <= valid_c_q;
      if (free_e) valid_e_q <= valid_d_q;
      if (out_free) out_valid_q <= valid_e_q && ctrl_e_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= ctrl_e_q.interior ? mean : center_e_q;
      out_last_q <= ctrl_e_q.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  a_fwd_single_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && fwd_d |-> cols_eff == CW'(1))
    else $error("line buffer bypass with more than one column");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && ctrl_in.emit && ctrl_in.last |=> in_col_q == '0 && out_row_q == '0)
    else $error("counters not cleared after last transfer of grid");

  a_out_from_e: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(valid_e_q && ctrl_e_q.emit))
    else $error("result without an emitting item in last stage");
`endif

endmodule
